>>> sv/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants of the record table engine.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RESULT_CAP  = 16;
  localparam int unsigned VIEW_MAX    = (TABLE_DEPTH < RESULT_CAP) ? TABLE_DEPTH : RESULT_CAP;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SORT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_VIEW    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] score;
    logic [7:0]  cls;
    logic [63:0] name;
  } record_t;

endpackage

>>> sv/record_table_engine.sv
// ----------------------------------------------------------------------------
// record_table_engine
// Packed table of records with append, prepend, find, remove, stable
// descending sort by score and an in-order view.
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_stall_o with cmd_i and the entry fields;
//   an item is taken when in_valid_i is high and in_stall_o is low.
//   output channel: out_valid_o / out_stall_i; every command gives one
//   result with last_o set, a non-empty view gives one result per entry.
// the table memory has one read and one write port, and each move of an
// entry is a read then a write. append, a full table, an empty view and
// the unused codes are answered straight from the idle state; prepend
// shifts every entry up by one place, find scans from the front, remove
// shifts the entries behind the match down, sort is an insertion sort,
// and view reads and emits one entry at a time.
// in_stall_o stays high from the taken item until its last result sits in
// the output register, so the next item is taken only once the last one
// is through. a stalled receiver holds the sequencer in place.
// reset clears the entry count and the output valid; table contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module record_table_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] entry_id_i,
  input  logic [15:0] entry_score_i,
  input  logic [7:0]  entry_class_i,
  input  logic [63:0] entry_name_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  position_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_score_o,
  output logic [7:0]  out_class_o,
  output logic [63:0] out_name_o,
  output logic [4:0]  count_o,
  output logic        last_o
);

  localparam int unsigned CNT_W = rte_pkg::CNT_W;
  localparam int unsigned IDX_W = rte_pkg::IDX_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_PREWR = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_FCMP  = 4'd4;
  localparam logic [3:0] S_RM    = 4'd5;
  localparam logic [3:0] S_RMWR  = 4'd6;
  localparam logic [3:0] S_SI    = 4'd7;
  localparam logic [3:0] S_SKEY  = 4'd8;
  localparam logic [3:0] S_SJ    = 4'd9;
  localparam logic [3:0] S_SCMP  = 4'd10;
  localparam logic [3:0] S_SPUT  = 4'd11;
  localparam logic [3:0] S_VRD   = 4'd12;
  localparam logic [3:0] S_VOUT  = 4'd13;
  localparam logic [3:0] S_RESP  = 4'd14;

  rte_pkg::record_t mem [rte_pkg::TABLE_DEPTH];
  rte_pkg::record_t rd_q, key_q, in_q, in_rec;

  logic [3:0]                  state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            ptr_q, ptr_d;
  logic [IDX_W-1:0]            j_q, j_d;
  logic [rte_pkg::CMD_W-1:0]   cmd_q;
  logic [rte_pkg::STATUS_W-1:0] resp_status_q, resp_status_d;
  logic [CNT_W-1:0]            resp_pos_q, resp_pos_d;
  logic                        key_load;

  logic                        mem_we, mem_re;
  logic [IDX_W-1:0]            mem_waddr, mem_raddr;
  rte_pkg::record_t            mem_wdata;

  logic                        accept, slot_free, out_load, view_load, view_last;
  logic [CNT_W-1:0]            view_n, ptr_inc, ptr_dec;

  logic                        out_valid_q;
  logic [rte_pkg::STATUS_W-1:0] status_q;
  logic [CNT_W-1:0]            pos_q;
  logic [CNT_W-1:0]            cnt_out_q;
  rte_pkg::record_t            out_rec_q;
  logic                        last_q;

  assign in_rec    = '{id: entry_id_i, score: entry_score_i, cls: entry_class_i,
                       name: entry_name_i};
  assign in_stall_o = (state_q != S_IDLE);
  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign ptr_inc   = ptr_q + CNT_W'(1);
  assign ptr_dec   = ptr_q - CNT_W'(1);
  assign view_n    = (count_q > CNT_W'(rte_pkg::VIEW_MAX)) ? CNT_W'(rte_pkg::VIEW_MAX) : count_q;
  assign view_last = (ptr_inc == view_n);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    j_d           = j_q;
    resp_status_d = resp_status_q;
    resp_pos_d    = resp_pos_q;
    key_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ptr_q[IDX_W-1:0];
    mem_wdata     = rd_q;
    mem_re        = 1'b0;
    mem_raddr     = ptr_q[IDX_W-1:0];
    out_load      = 1'b0;
    view_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          resp_status_d = rte_pkg::ST_OK;
          resp_pos_d    = '0;
          ptr_d         = '0;
          state_d       = S_RESP;
          unique case (cmd_i) inside
            rte_pkg::CMD_APPEND: begin
              if (count_q == CNT_W'(rte_pkg::TABLE_DEPTH)) begin
                resp_status_d = rte_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = in_rec;
                count_d   = count_q + CNT_W'(1);
              end
            end
            rte_pkg::CMD_PREPEND: begin
              if (count_q == CNT_W'(rte_pkg::TABLE_DEPTH)) begin
                resp_status_d = rte_pkg::ST_FULL;
              end else begin
                ptr_d   = count_q;
                state_d = S_PRE;
              end
            end
            rte_pkg::CMD_FIND, rte_pkg::CMD_REMOVE: begin
              state_d = S_FRD;
            end
            rte_pkg::CMD_SORT: begin
              ptr_d   = CNT_W'(1);
              state_d = S_SI;
            end
            rte_pkg::CMD_VIEW: begin
              if (count_q == '0) begin
                resp_status_d = rte_pkg::ST_EMPTY;
              end else begin
                state_d = S_VRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_PRE: begin
        if (ptr_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = in_q;
          count_d   = count_q + CNT_W'(1);
          state_d   = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[IDX_W-1:0];
          state_d   = S_PREWR;
        end
      end
      S_PREWR: begin
        mem_we  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_PRE;
      end
      S_FRD: begin
        if (ptr_q == count_q) begin
          resp_status_d = rte_pkg::ST_NOT_FOUND;
          state_d       = S_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (rd_q.id == in_q.id) begin
          if (cmd_q == rte_pkg::CMD_FIND) begin
            resp_pos_d = ptr_q;
            state_d    = S_RESP;
          end else begin
            state_d = S_RM;
          end
        end else begin
          ptr_d   = ptr_inc;
          state_d = S_FRD;
        end
      end
      S_RM: begin
        if (ptr_inc >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[IDX_W-1:0];
          state_d   = S_RMWR;
        end
      end
      S_RMWR: begin
        mem_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_RM;
      end
      S_SI: begin
        if (ptr_q >= count_q) begin
          state_d = S_RESP;
        end else begin
          mem_re  = 1'b1;
          j_d     = ptr_q[IDX_W-1:0];
          state_d = S_SKEY;
        end
      end
      S_SKEY: begin
        key_load = 1'b1;
        state_d  = S_SJ;
      end
      S_SJ: begin
        if (j_q == '0) begin
          state_d = S_SPUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = j_q - IDX_W'(1);
          state_d   = S_SCMP;
        end
      end
      S_SCMP: begin
        if (key_q.score > rd_q.score) begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          j_d       = j_q - IDX_W'(1);
          state_d   = S_SJ;
        end else begin
          state_d = S_SPUT;
        end
      end
      S_SPUT: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = key_q;
        ptr_d     = ptr_inc;
        state_d   = S_SI;
      end
      S_VRD: begin
        mem_re  = 1'b1;
        state_d = S_VOUT;
      end
      S_VOUT: begin
        if (slot_free) begin
          view_load = 1'b1;
          if (view_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_VRD;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q  <= in_rec;
      cmd_q <= cmd_i;
    end
    if (key_load) begin
      key_q <= rd_q;
    end
    resp_status_q <= resp_status_d;
    resp_pos_q    <= resp_pos_d;
    j_q           <= j_d;
    ptr_q         <= ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load || view_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= resp_status_q;
      pos_q     <= resp_pos_q;
      cnt_out_q <= count_q;
      out_rec_q <= '0;
      last_q    <= 1'b1;
    end else if (view_load) begin
      status_q  <= rte_pkg::ST_OK;
      pos_q     <= ptr_q;
      cnt_out_q <= count_q;
      out_rec_q <= rd_q;
      last_q    <= view_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = rte_pkg::POS_W'(pos_q);
  assign out_id_o    = out_rec_q.id;
  assign out_score_o = out_rec_q.score;
  assign out_class_o = out_rec_q.cls;
  assign out_name_o  = out_rec_q.name;
  assign count_o     = rte_pkg::COUNT_W'(cnt_out_q);
  assign last_o      = last_q;

endmodule

>>> sv/rte_checker.sv
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks of the record table engine, bound to the top level.
// ----------------------------------------------------------------------------
module rte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [4:0]  count_o,
  input logic        last_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every taken item closes the input in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an item");

  // an empty answer only on an empty table, as the final result
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rte_pkg::ST_EMPTY |-> count_o == '0 && last_o)
    else $error("empty status with entries present");

  // a full answer only on a full table
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rte_pkg::ST_FULL
      |-> count_o == rte_pkg::COUNT_W'(rte_pkg::TABLE_DEPTH) && last_o)
    else $error("full status on a table with room");

  // count never goes past the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= rte_pkg::COUNT_W'(rte_pkg::TABLE_DEPTH))
    else $error("count beyond table depth");

endmodule

bind record_table_engine rte_checker u_rte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .count_o     (count_o),
  .last_o      (last_o)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the record table engine. A short table of directed
// commands (empty table, full table, missing ids, extremes, unused codes) is
// followed by a random command stream that alternates filling and draining.
// Results are checked against a behavioral copy of the table in the bench or
// typed rows' fixed status and count, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [rte_pkg::CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [rte_pkg::CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam int RANDOM_ITEMS = 420;
  localparam int PHASE_ITEMS  = 60;
  localparam int IDLE_PCT     = 21;
  localparam int CALM_FROM    = 150;
  localparam int CALM_TO      = 230;
  localparam int HOLD_AT      = 320;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;
  localparam int ROW_COUNT    = 20;

  typedef struct packed {
    logic [rte_pkg::STATUS_W-1:0] status;
    logic [rte_pkg::POS_W-1:0]    position;
    rte_pkg::record_t             rec;
    logic [rte_pkg::COUNT_W-1:0]  count;
    logic                         last;
  } table_result_t;

  typedef struct {
    logic [rte_pkg::CMD_W-1:0]    cmd;
    rte_pkg::record_t             rec;
    int                           rpt;
    bit                           typed;
    logic [rte_pkg::STATUS_W-1:0] t_status;
    logic [rte_pkg::COUNT_W-1:0]  t_count;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [31:0] entry_id_i = '0;
  logic [15:0] entry_score_i = '0;
  logic [7:0]  entry_class_i = '0;
  logic [63:0] entry_name_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  position_o;
  logic [31:0] out_id_o;
  logic [15:0] out_score_o;
  logic [7:0]  out_class_o;
  logic [63:0] out_name_o;
  logic [4:0]  count_o;
  logic        last_o;

  rte_pkg::record_t shadow_tab [rte_pkg::TABLE_DEPTH];
  int               shadow_cnt = 0;
  table_result_t    step_results [$];
  table_result_t    expected_results [$];
  stim_row_t        dir_rows [ROW_COUNT];
  int               items_sent = 0;
  int               mismatches = 0;
  int               cycle_count = 0;
  bit               held_off = 1'b0;

  record_table_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .entry_id_i    (entry_id_i),
    .entry_score_i (entry_score_i),
    .entry_class_i (entry_class_i),
    .entry_name_i  (entry_name_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .out_id_o      (out_id_o),
    .out_score_o   (out_score_o),
    .out_class_o   (out_class_o),
    .out_name_o    (out_name_o),
    .count_o       (count_o),
    .last_o        (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit calm_window();
    return items_sent >= CALM_FROM && items_sent < CALM_TO;
  endfunction

  function automatic void note_result(input logic [rte_pkg::STATUS_W-1:0] status,
                                      input int pos, input rte_pkg::record_t rec,
                                      input bit last);
    table_result_t res;
    res.status   = status;
    res.position = pos[rte_pkg::POS_W-1:0];
    res.rec      = rec;
    res.count    = shadow_cnt[rte_pkg::COUNT_W-1:0];
    res.last     = last;
    step_results.push_back(res);
  endfunction

  // table model: updates the shadow copy and lists the results of one command
  function automatic void apply_command(input logic [rte_pkg::CMD_W-1:0] cmd,
                                        input rte_pkg::record_t rec);
    int               i;
    int               j;
    int               at;
    int               n;
    rte_pkg::record_t held;
    at = -1;
    step_results.delete();
    if (cmd == rte_pkg::CMD_FIND || cmd == rte_pkg::CMD_REMOVE) begin
      for (i = shadow_cnt - 1; i >= 0; i--) begin
        if (shadow_tab[i].id == rec.id) at = i;
      end
    end
    case (cmd) inside
      rte_pkg::CMD_APPEND, rte_pkg::CMD_PREPEND: begin
        if (shadow_cnt >= rte_pkg::TABLE_DEPTH) begin
          note_result(rte_pkg::ST_FULL, 0, '0, 1'b1);
        end else begin
          if (cmd == rte_pkg::CMD_PREPEND) begin
            for (i = shadow_cnt; i > 0; i--) shadow_tab[i] = shadow_tab[i-1];
            shadow_tab[0] = rec;
          end else begin
            shadow_tab[shadow_cnt] = rec;
          end
          shadow_cnt++;
          note_result(rte_pkg::ST_OK, 0, '0, 1'b1);
        end
      end
      rte_pkg::CMD_FIND: begin
        if (at < 0) note_result(rte_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
        else note_result(rte_pkg::ST_OK, at, '0, 1'b1);
      end
      rte_pkg::CMD_REMOVE: begin
        if (at < 0) begin
          note_result(rte_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
        end else begin
          for (i = at; i + 1 < shadow_cnt; i++) shadow_tab[i] = shadow_tab[i+1];
          shadow_cnt--;
          note_result(rte_pkg::ST_OK, 0, '0, 1'b1);
        end
      end
      rte_pkg::CMD_SORT: begin
        for (i = 1; i < shadow_cnt; i++) begin
          held = shadow_tab[i];
          j = i;
          while (j > 0 && held.score > shadow_tab[j-1].score) begin
            shadow_tab[j] = shadow_tab[j-1];
            j--;
          end
          shadow_tab[j] = held;
        end
        note_result(rte_pkg::ST_OK, 0, '0, 1'b1);
      end
      rte_pkg::CMD_VIEW: begin
        n = (shadow_cnt < rte_pkg::RESULT_CAP) ? shadow_cnt : rte_pkg::RESULT_CAP;
        if (n == 0) begin
          note_result(rte_pkg::ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) note_result(rte_pkg::ST_OK, i, shadow_tab[i], i == n - 1);
        end
      end
      default: note_result(rte_pkg::ST_OK, 0, '0, 1'b1);
    endcase
  endfunction

  function automatic stim_row_t mk_row(input logic [rte_pkg::CMD_W-1:0] cmd,
                                      input logic [31:0] id,
                                      input logic [15:0] score, input logic [7:0] cls,
                                      input logic [63:0] name, input int rpt, input bit typed,
                                      input logic [rte_pkg::STATUS_W-1:0] t_status,
                                      input logic [rte_pkg::COUNT_W-1:0] t_count);
    stim_row_t row;
    row.cmd       = cmd;
    row.rec.id    = id;
    row.rec.score = score;
    row.rec.cls   = cls;
    row.rec.name  = name;
    row.rpt       = rpt;
    row.typed     = typed;
    row.t_status  = t_status;
    row.t_count   = t_count;
    return row;
  endfunction

  task automatic send_command(input logic [rte_pkg::CMD_W-1:0] cmd,
                              input rte_pkg::record_t rec, input bit typed,
                              input logic [rte_pkg::STATUS_W-1:0] t_status,
                              input logic [rte_pkg::COUNT_W-1:0] t_count);
    table_result_t fixed;
    while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    entry_id_i    <= rec.id;
    entry_score_i <= rec.score;
    entry_class_i <= rec.cls;
    entry_name_i  <= rec.name;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    apply_command(cmd, rec);
    if (typed) begin
      fixed        = '0;
      fixed.status = t_status;
      fixed.count  = t_count;
      fixed.last   = 1'b1;
      expected_results.push_back(fixed);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    table_result_t seen;
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status    = status_o;
      seen.position  = position_o;
      seen.rec.id    = out_id_o;
      seen.rec.score = out_score_o;
      seen.rec.cls   = out_class_o;
      seen.rec.name  = out_name_o;
      seen.count     = count_o;
      seen.last      = last_o;
      if (expected_results.size() == 0) begin
        if (mismatches < REPORT_MAX) $display("error: unexpected item, id %h", out_id_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (seen.status !== want.status || seen.position !== want.position ||
            seen.rec.id !== want.rec.id || seen.rec.score !== want.rec.score ||
            seen.rec.cls !== want.rec.cls || seen.rec.name !== want.rec.name ||
            seen.count !== want.count || seen.last !== want.last) begin
          if (mismatches < REPORT_MAX) begin
            $display("error: exp st %0d pos %0d id %h sc %h cl %h nm %h cnt %0d last %b",
                     want.status, want.position, want.rec.id, want.rec.score, want.rec.cls,
                     want.rec.name, want.count, want.last);
            $display("       got st %0d pos %0d id %h sc %h cl %h nm %h cnt %0d last %b",
                     seen.status, seen.position, seen.rec.id, seen.rec.score, seen.rec.cls,
                     seen.rec.name, seen.count, seen.last);
          end
          mismatches++;
        end
      end
    end
  end

  // receiver side, with one long hold-off so the block backs up
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held_off && items_sent >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm_window() && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("record_table_engine: mismatch");
      $finish;
    end
  end

  initial begin
    int                        r;
    int                        k;
    int                        n;
    int                        pick;
    bit                        filling;
    rte_pkg::record_t          rec;
    logic [rte_pkg::CMD_W-1:0] cmd;

    filling = 1'b0;
    dir_rows[0]  = mk_row(rte_pkg::CMD_VIEW, '0, '0, '0, '0, 1, 1'b1,
                          rte_pkg::ST_EMPTY, 5'd0);
    dir_rows[1]  = mk_row(rte_pkg::CMD_FIND, '0, '0, '0, '0, 1, 1'b1,
                          rte_pkg::ST_NOT_FOUND, 5'd0);
    dir_rows[2]  = mk_row(rte_pkg::CMD_REMOVE, '1, '0, '0, '0, 1, 1'b1,
                          rte_pkg::ST_NOT_FOUND, 5'd0);
    dir_rows[3]  = mk_row(rte_pkg::CMD_SORT, '0, '0, '0, '0, 1, 1'b1, rte_pkg::ST_OK, 5'd0);
    dir_rows[4]  = mk_row(CMD_UNUSED_7, '1, '1, '1, '1, 1, 1'b1, rte_pkg::ST_OK, 5'd0);
    dir_rows[5]  = mk_row(rte_pkg::CMD_APPEND, '0, '0, '0, '0, 1, 1'b1, rte_pkg::ST_OK, 5'd1);
    dir_rows[6]  = mk_row(rte_pkg::CMD_APPEND, '1, '1, '1, '1, 1, 1'b1, rte_pkg::ST_OK, 5'd2);
    // repeated rows step id and score so ids repeat and scores tie
    dir_rows[7]  = mk_row(rte_pkg::CMD_PREPEND, 32'h100, 16'h10, 8'h5a,
                          64'h0123_4567_89ab_cdef, 13, 1'b0, rte_pkg::ST_OK, 5'd0);
    dir_rows[8]  = mk_row(rte_pkg::CMD_APPEND, 32'h200, 16'h8000, 8'h80,
                          64'h8000_0000_0000_0001, 1, 1'b1, rte_pkg::ST_OK, 5'd16);
    dir_rows[9]  = mk_row(rte_pkg::CMD_APPEND, 32'h201, 16'h1, 8'h1, 64'h1, 1, 1'b1,
                          rte_pkg::ST_FULL, 5'd16);
    dir_rows[10] = mk_row(rte_pkg::CMD_PREPEND, 32'h202, 16'h2, 8'h2, 64'h2, 1, 1'b1,
                          rte_pkg::ST_FULL, 5'd16);
    dir_rows[11] = mk_row(rte_pkg::CMD_FIND, 32'h102, '0, '0, '0, 1, 1'b0,
                          rte_pkg::ST_OK, 5'd0);
    dir_rows[12] = mk_row(rte_pkg::CMD_VIEW, '0, '0, '0, '0, 1, 1'b0, rte_pkg::ST_OK, 5'd0);
    dir_rows[13] = mk_row(rte_pkg::CMD_SORT, '0, '0, '0, '0, 1, 1'b0, rte_pkg::ST_OK, 5'd0);
    dir_rows[14] = mk_row(rte_pkg::CMD_VIEW, '0, '0, '0, '0, 1, 1'b0, rte_pkg::ST_OK, 5'd0);
    dir_rows[15] = mk_row(rte_pkg::CMD_REMOVE, 32'h102, '0, '0, '0, 1, 1'b0,
                          rte_pkg::ST_OK, 5'd0);
    dir_rows[16] = mk_row(rte_pkg::CMD_REMOVE, '1, '0, '0, '0, 1, 1'b0, rte_pkg::ST_OK, 5'd0);
    dir_rows[17] = mk_row(rte_pkg::CMD_FIND, 32'hdead_beef, '0, '0, '0, 1, 1'b1,
                          rte_pkg::ST_NOT_FOUND, 5'd14);
    dir_rows[18] = mk_row(CMD_UNUSED_6, '0, '0, '0, '0, 1, 1'b1, rte_pkg::ST_OK, 5'd14);
    dir_rows[19] = mk_row(rte_pkg::CMD_VIEW, '0, '0, '0, '0, 1, 1'b0, rte_pkg::ST_OK, 5'd0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < ROW_COUNT; r++) begin
      for (k = 0; k < dir_rows[r].rpt; k++) begin
        rec       = dir_rows[r].rec;
        rec.id    = rec.id + 32'(k % 5);
        rec.score = rec.score + 16'((k % 4) * 16);
        rec.name  = rec.name + 64'(k);
        send_command(dir_rows[r].cmd, rec, dir_rows[r].typed, dir_rows[r].t_status,
                     dir_rows[r].t_count);
      end
    end

    // alternate fill-heavy and drain-heavy phases
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 5) cmd = pick[0] ? CMD_UNUSED_7 : CMD_UNUSED_6;
      else if (pick < 13) cmd = rte_pkg::CMD_SORT;
      else if (pick < 25) cmd = rte_pkg::CMD_VIEW;
      else if (pick < 40) cmd = rte_pkg::CMD_FIND;
      else if (filling)
        cmd = (pick < 52) ? rte_pkg::CMD_REMOVE :
              ((pick < 76) ? rte_pkg::CMD_APPEND : rte_pkg::CMD_PREPEND);
      else
        cmd = (pick < 80) ? rte_pkg::CMD_REMOVE :
              ((pick < 90) ? rte_pkg::CMD_APPEND : rte_pkg::CMD_PREPEND);
      rec.score = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                       : 16'($urandom_range(0, 65535));
      rec.cls   = 8'($urandom_range(0, 255));
      rec.name  = {$urandom, $urandom};
      if ((cmd == rte_pkg::CMD_FIND || cmd == rte_pkg::CMD_REMOVE) && shadow_cnt > 0 &&
          $urandom_range(0, 3) != 0)
        rec.id = shadow_tab[$urandom_range(0, shadow_cnt - 1)].id;
      else if ($urandom_range(0, 2) != 0)
        rec.id = 32'h0000_1000 + 32'($urandom_range(0, 15));
      else
        rec.id = $urandom;
      send_command(cmd, rec, 1'b0, rte_pkg::ST_OK, '0);
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("record_table_engine: match");
    end else begin
      $display("record_table_engine: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rte_pkg.sv
sv/record_table_engine.sv
sv/rte_checker.sv
bench/tb.sv
